FILE: rtl/active_list_remove_with_standby_refill_macros.svh
`ifndef ACTIVE_LIST_REMOVE_WITH_STANDBY_REFILL_MACROS_SVH
`define ACTIVE_LIST_REMOVE_WITH_STANDBY_REFILL_MACROS_SVH

// same-cycle implication
`define ALRSR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port check failed");

// next-cycle implication
`define ALRSR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

FILE: rtl/alrsr_pkg.sv
package alrsr_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int ID_WIDTH   = 16;
   localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   localparam int SLOT_W     = 4;
   localparam int FIELD_ID_W = 16;
   localparam int KIND_W     = 2;
   localparam int DATA_W     = 24;

   localparam logic [KIND_W-1:0] REQ_LOAD_ACTIVE  = 2'd0;
   localparam logic [KIND_W-1:0] REQ_LOAD_STANDBY = 2'd1;
   localparam logic [KIND_W-1:0] REQ_REMOVE       = 2'd2;

   localparam logic [KIND_W-1:0] ST_LOADED    = 2'd0;
   localparam logic [KIND_W-1:0] ST_REMOVED   = 2'd1;
   localparam logic [KIND_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [KIND_W-1:0] ST_IGNORED   = 2'd3;

   typedef struct packed {
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic hit;
   } stat_type;

endpackage

FILE: rtl/active_list_remove_with_standby_refill.sv
// Active list with standby refill.
// Request channel (req_*): req_tuser carries the request kind (load active
// slot, load standby slot, remove by ID); req_tdata carries the entry ID and
// the slot index. Response channel (rsp_*): rsp_tuser carries the status
// (loaded, removed, not found, ignored); rsp_tdata carries the slot where the
// removed ID stood and the standby ID that moved into the active tail.
// Every request yields exactly one response, in request order.
// The response is valid in the cycle after the request is taken.
// Throughput: one request per cycle while responses are read; the search
// compares all active slots at once; the close-up shift is one register update.
// The response register frees up as it is read, so a new request is taken
// in the same cycle the previous response is taken.
// When the receiver stalls, the response holds and req_tready drops until
// the response is taken.
// Reset (synchronous, active high) empties both lists and drops rsp_tvalid.
module active_list_remove_with_standby_refill
   import alrsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,  // entry_id[15:0], slot_index[19:16], zero
   input  logic [KIND_W-1:0] req_tuser,  // req_type[1:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,  // found_slot[3:0], promoted_id[19:4], zero
   output logic [KIND_W-1:0] rsp_tuser   // status[1:0]
);

   cmd_type               cmd;
   stat_type              stat;
   logic                  hit_seen;
   logic [SLOT_W-1:0]     found_slot;
   logic [FIELD_ID_W-1:0] promoted_id;

   alrsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd),
      .hit_seen   (hit_seen)
   );

   alrsr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_type    (req_tuser),
      .entry_id    (req_tdata[FIELD_ID_W-1:0]),
      .slot_index  (req_tdata[FIELD_ID_W+SLOT_W-1:FIELD_ID_W]),
      .stat        (stat),
      .status      (rsp_tuser),
      .found_slot  (found_slot),
      .promoted_id (promoted_id)
   );

   // zero the slot field unless the held response is a removal
   assign rsp_tdata = {{(DATA_W - SLOT_W - FIELD_ID_W){1'b0}}, promoted_id,
                       hit_seen ? found_slot : {SLOT_W{1'b0}}};

endmodule

FILE: rtl/alrsr_ctrl.sv
module alrsr_ctrl
   import alrsr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  stat_type stat,
   output cmd_type cmd,
   output logic    hit_seen
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_HOLD = 1'b1;

   logic state_ff;
   logic state_in;
   logic hit_ff;
   logic hit_in;
   logic accept;

   assign req_tready = (state_ff == S_IDLE) || rsp_tready;
   assign rsp_tvalid = (state_ff == S_HOLD);
   assign accept     = req_tvalid && req_tready;
   assign cmd.exec   = accept;
   assign hit_seen   = hit_ff;

   always_comb begin
      state_in = state_ff;
      hit_in   = hit_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_HOLD;
               hit_in   = stat.hit;
            end
         end
         S_HOLD: begin
            if (accept) begin
               state_in = S_HOLD;
               hit_in   = stat.hit;
            end else if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
      end
   end

endmodule

FILE: rtl/alrsr_dp.sv
module alrsr_dp
   import alrsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [KIND_W-1:0]     req_type,
   input  logic [FIELD_ID_W-1:0] entry_id,
   input  logic [SLOT_W-1:0]     slot_index,
   output stat_type              stat,
   output logic [KIND_W-1:0]     status,
   output logic [SLOT_W-1:0]     found_slot,
   output logic [FIELD_ID_W-1:0] promoted_id
);

   logic [ID_WIDTH-1:0]   active_ff  [LIST_DEPTH];
   logic [ID_WIDTH-1:0]   active_in  [LIST_DEPTH];
   logic [ID_WIDTH-1:0]   standby_ff [LIST_DEPTH];
   logic [ID_WIDTH-1:0]   standby_in [LIST_DEPTH];
   logic [KIND_W-1:0]     status_ff;
   logic [KIND_W-1:0]     status_in;
   logic [SLOT_W-1:0]     found_slot_ff;
   logic [SLOT_W-1:0]     found_slot_in;
   logic [FIELD_ID_W-1:0] promoted_ff;
   logic [FIELD_ID_W-1:0] promoted_in;

   logic [ID_WIDTH-1:0]   id;
   logic [LIST_DEPTH-1:0] match;
   logic [LIST_DEPTH-1:0] shift_mask;
   logic [IDX_W-1:0]      pos;
   logic                  hit;
   logic                  do_remove;

   assign id        = ID_WIDTH'(entry_id);
   assign hit       = |match;
   assign do_remove = (req_type == REQ_REMOVE) && (id != '0) && hit;
   assign stat.hit  = do_remove;

   always_comb begin
      pos = '0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         match[k] = (active_ff[k] == id);
      end
      shift_mask[0] = match[0];
      for (int k = 1; k < LIST_DEPTH; k++) begin
         shift_mask[k] = shift_mask[k-1] | match[k];
      end
      for (int k = LIST_DEPTH - 1; k >= 0; k--) begin
         if (match[k]) begin
            pos = IDX_W'(k);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < LIST_DEPTH; k++) begin
         active_in[k]  = active_ff[k];
         standby_in[k] = standby_ff[k];
      end
      status_in     = status_ff;
      found_slot_in = found_slot_ff;
      promoted_in   = promoted_ff;
      if (cmd.exec) begin
         found_slot_in = '0;
         promoted_in   = '0;
         case (req_type)
            REQ_LOAD_ACTIVE: begin
               status_in = ST_LOADED;
               for (int k = 0; k < LIST_DEPTH; k++) begin
                  if (int'(slot_index) == k) begin
                     active_in[k] = id;
                  end
               end
            end
            REQ_LOAD_STANDBY: begin
               status_in = ST_LOADED;
               for (int k = 0; k < LIST_DEPTH; k++) begin
                  if (int'(slot_index) == k) begin
                     standby_in[k] = id;
                  end
               end
            end
            REQ_REMOVE: begin
               if (id == '0) begin
                  status_in = ST_IGNORED;
               end else if (!hit) begin
                  status_in = ST_NOT_FOUND;
               end else begin
                  status_in     = ST_REMOVED;
                  found_slot_in = SLOT_W'(pos);
                  promoted_in   = FIELD_ID_W'(standby_ff[0]);
                  for (int k = 0; k < LIST_DEPTH - 1; k++) begin
                     if (shift_mask[k]) begin
                        active_in[k] = active_ff[k+1];
                     end
                     standby_in[k] = standby_ff[k+1];
                  end
                  active_in[LIST_DEPTH-1]  = standby_ff[0];
                  standby_in[LIST_DEPTH-1] = '0;
               end
            end
            default: begin
               status_in = ST_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LIST_DEPTH; k++) begin
            active_ff[k]  <= '0;
            standby_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < LIST_DEPTH; k++) begin
            active_ff[k]  <= active_in[k];
            standby_ff[k] <= standby_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      found_slot_ff <= found_slot_in;
      promoted_ff   <= promoted_in;
   end

   assign status      = status_ff;
   assign found_slot  = found_slot_ff;
   assign promoted_id = promoted_ff;

endmodule

FILE: rtl/alrsr_checker.sv
`include "active_list_remove_with_standby_refill_macros.svh"

module alrsr_checker
   import alrsr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [DATA_W-1:0] req_tdata,
   input logic [KIND_W-1:0] req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic [KIND_W-1:0] rsp_tuser
);

   logic req_fire;
   logic rsp_stall;
   logic rsp_plain;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_plain = rsp_tvalid && (rsp_tuser != ST_REMOVED);

   `ALRSR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `ALRSR_ASSERT_NOW(a_no_take_on_stall, clock, reset, rsp_stall, !req_tready)
   `ALRSR_ASSERT_NEXT(a_rsp_follows, clock, reset, req_fire, rsp_tvalid)
   `ALRSR_ASSERT_NOW(a_plain_zero, clock, reset, rsp_plain, rsp_tdata == '0)

endmodule

bind active_list_remove_with_standby_refill alrsr_checker u_alrsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: verif/tb_active_list_remove_with_standby_refill.sv
module tb_active_list_remove_with_standby_refill
   import alrsr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
   localparam int PHASE_ITEMS    = 400;
   localparam int LONG_HOLD      = 120;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 10;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [FIELD_ID_W-1:0] entry_id;
      logic [SLOT_W-1:0]     slot_index;
   } list_req_type;

   typedef struct packed {
      logic [KIND_W-1:0]     status;
      logic [SLOT_W-1:0]     found_slot;
      logic [FIELD_ID_W-1:0] promoted_id;
   } list_rsp_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0] req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;

   list_req_type pending_requests[$];
   list_rsp_type expected_responses[$];

   logic [ID_WIDTH-1:0] model_active[LIST_DEPTH];
   logic [ID_WIDTH-1:0] model_standby[LIST_DEPTH];

   int  req_idle_pct   = 0;
   int  rsp_stall_pct  = 0;
   int  hold_requests  = 0;
   int  hold_served    = 0;
   int  hold_left      = 0;
   int  error_count    = 0;
   int  quiet_cycles   = 0;
   logic req_taken     = 1'b0;

   active_list_remove_with_standby_refill DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic list_rsp_type predict_list_update(list_req_type r);
      list_rsp_type        res;
      int                  hit;
      logic [ID_WIDTH-1:0] head;
      res = '0;
      hit = -1;
      case (r.kind)
         REQ_LOAD_ACTIVE, REQ_LOAD_STANDBY: begin
            if (int'(r.slot_index) < LIST_DEPTH) begin
               if (r.kind == REQ_LOAD_ACTIVE)
                  model_active[r.slot_index] = r.entry_id[ID_WIDTH-1:0];
               else
                  model_standby[r.slot_index] = r.entry_id[ID_WIDTH-1:0];
            end
            res.status = ST_LOADED;
         end
         REQ_REMOVE: begin
            if (r.entry_id[ID_WIDTH-1:0] == '0) begin
               res.status = ST_IGNORED;
            end else begin
               for (int k = 0; k < LIST_DEPTH; k++)
                  if (hit < 0 && model_active[k] == r.entry_id[ID_WIDTH-1:0])
                     hit = k;
               if (hit < 0) begin
                  res.status = ST_NOT_FOUND;
               end else begin
                  for (int k = hit; k < LIST_DEPTH - 1; k++)
                     model_active[k] = model_active[k+1];
                  head = model_standby[0];
                  model_active[LIST_DEPTH-1] = head;
                  for (int k = 0; k < LIST_DEPTH - 1; k++)
                     model_standby[k] = model_standby[k+1];
                  model_standby[LIST_DEPTH-1] = '0;
                  res.status      = ST_REMOVED;
                  res.found_slot  = SLOT_W'(hit);
                  res.promoted_id = FIELD_ID_W'(head);
               end
            end
         end
         default: res.status = ST_IGNORED;
      endcase
      return res;
   endfunction

   task automatic push_request(logic [KIND_W-1:0] kind, logic [FIELD_ID_W-1:0] id,
                               logic [SLOT_W-1:0] slot);
      list_req_type r;
      r.kind       = kind;
      r.entry_id   = id;
      r.slot_index = slot;
      pending_requests.push_back(r);
   endtask

   // request driver
   always @(negedge clock) begin
      list_req_type nxt;
      logic         send;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         send = (pending_requests.size() != 0) && ($urandom_range(0, 99) >= req_idle_pct);
         if (send) begin
            nxt = pending_requests.pop_front();
            req_tdata <= {{(DATA_W-SLOT_W-FIELD_ID_W){1'b0}}, nxt.slot_index, nxt.entry_id};
            req_tuser <= nxt.kind;
         end
         req_tvalid <= send;
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         rsp_tready  <= 1'b0;
         hold_left   <= LONG_HOLD - 1;
         hold_served <= hold_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // monitor: predict on request, check on response
   always @(posedge clock) begin
      list_req_type r;
      list_rsp_type got;
      list_rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            r.kind       = req_tuser;
            r.entry_id   = req_tdata[FIELD_ID_W-1:0];
            r.slot_index = req_tdata[FIELD_ID_W +: SLOT_W];
            expected_responses.push_back(predict_list_update(r));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status      = rsp_tuser;
            got.found_slot  = rsp_tdata[SLOT_W-1:0];
            got.promoted_id = rsp_tdata[SLOT_W +: FIELD_ID_W];
            if (expected_responses.size() == 0) begin
               $error("unexpected response: status %0d found_slot %0d promoted_id %h",
                      got.status, got.found_slot, got.promoted_id);
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  error_count++;
               end
               if (got.found_slot !== want.found_slot) begin
                  $error("found_slot: expected %0d, actual %0d",
                         want.found_slot, got.found_slot);
                  error_count++;
               end
               if (got.promoted_id !== want.promoted_id) begin
                  $error("promoted_id: expected %h, actual %h",
                         want.promoted_id, got.promoted_id);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int idle_by_phase[4];
      int stall_by_phase[4];
      int roll;
      logic [KIND_W-1:0]     kind;
      logic [FIELD_ID_W-1:0] id;

      idle_by_phase  = '{0, 46, 0, 8};
      stall_by_phase = '{0, 0, 46, 8};
      for (int k = 0; k < LIST_DEPTH; k++) begin
         model_active[k]  = '0;
         model_standby[k] = '0;
      end

      // directed: extremes, duplicates, misses, ignored kinds
      push_request(REQ_REMOVE,       16'h0001, 4'd0);
      push_request(REQ_LOAD_ACTIVE,  16'hFFFF, 4'd0);
      push_request(REQ_LOAD_ACTIVE,  16'h0001, 4'd15);
      push_request(REQ_LOAD_ACTIVE,  16'hFFFF, 4'd5);
      push_request(REQ_LOAD_ACTIVE,  16'h5A5A, 4'd10);
      push_request(REQ_LOAD_STANDBY, 16'h8000, 4'd0);
      push_request(REQ_LOAD_STANDBY, 16'h7FFF, 4'd15);
      push_request(REQ_LOAD_STANDBY, 16'hA5A5, 4'd1);
      push_request(REQ_REMOVE,       16'hFFFF, 4'd9);
      push_request(REQ_REMOVE,       16'hFFFF, 4'd0);
      push_request(REQ_REMOVE,       16'h1234, 4'd0);
      push_request(REQ_REMOVE,       16'h0000, 4'd3);
      push_request(REQ_UNUSED,       16'hFFFF, 4'd15);
      push_request(REQ_UNUSED,       16'h0000, 4'd0);
      push_request(REQ_LOAD_ACTIVE,  16'h0000, 4'd14);
      push_request(REQ_REMOVE,       16'h0001, 4'd15);
      push_request(REQ_REMOVE,       16'h5A5A, 4'd0);
      push_request(REQ_REMOVE,       16'h8000, 4'd0);
      push_request(REQ_REMOVE,       16'h7FFF, 4'd0);
      push_request(REQ_LOAD_STANDBY, 16'h0000, 4'd15);
      push_request(REQ_REMOVE,       16'hA5A5, 4'd0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         do @(posedge clock); while (pending_requests.size() != 0 || req_tvalid);
         do @(negedge clock); while (expected_responses.size() != 0);
         @(posedge clock);
         req_idle_pct  = idle_by_phase[phase];
         rsp_stall_pct = stall_by_phase[phase];
         if (phase == 0)
            hold_requests++;
         // small ID pool keeps removes hitting; full-range IDs toggle every bit
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30)      kind = REQ_LOAD_ACTIVE;
            else if (roll < 55) kind = REQ_LOAD_STANDBY;
            else if (roll < 95) kind = REQ_REMOVE;
            else                kind = REQ_UNUSED;
            roll = $urandom_range(0, 99);
            if (roll < 60)      id = FIELD_ID_W'($urandom_range(1, 12));
            else if (roll < 68) id = '0;
            else                id = FIELD_ID_W'($urandom_range(0, 65535));
            push_request(kind, id, SLOT_W'($urandom_range(0, 15)));
         end
      end

      do @(posedge clock); while (pending_requests.size() != 0 || req_tvalid);
      do @(negedge clock); while (expected_responses.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
